[hdl/bmp24_stream_writer_core_macros.svh]
// ---------------------------------------------------------------------------
// bmp24 stream writer assertion macros
// shared property forms for the port checker
// ---------------------------------------------------------------------------
`ifndef BMP24_STREAM_WRITER_CORE_MACROS_SVH
`define BMP24_STREAM_WRITER_CORE_MACROS_SVH

// same-cycle implication, ignored during reset
`define BSW_ASSERT_IMPLIES(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed: label");

// next-cycle implication, ignored during reset
`define BSW_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed: label");

// next-cycle implication that also holds across reset
`define BSW_ASSERT_NEXT_ALWAYS(label, clk, a, b) \
   label: assert property (@(posedge clk) (a) |=> (b)) \
      else $error("assertion failed: label");

`endif

[hdl/bmp24sw_pkg.sv]
// ---------------------------------------------------------------------------
// bmp24 stream writer package
// widths, register indexes, byte sequence positions and the item record
// ---------------------------------------------------------------------------
package bmp24sw_pkg;

   // frame dimension width
   localparam int DIM_BITS = 12;
   localparam int ROW_BITS = DIM_BITS + 2;
   localparam int IMG_BITS = ROW_BITS + DIM_BITS;

   localparam int PIX_BITS  = 16;
   localparam int BYTE_BITS = 8;

   // configuration register indexes
   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   localparam logic [DIM_BITS-1:0] WIDTH_RESET  = DIM_BITS'(800);
   localparam logic [DIM_BITS-1:0] HEIGHT_RESET = DIM_BITS'(480);

   // header constants
   localparam int HDR_LEN  = 54;
   localparam int INFO_LEN = 40;
   localparam int BPP      = 24;

   // position of each byte in the sequence caused by one pixel
   localparam int IDX_BITS = 6;
   localparam logic [IDX_BITS-1:0] IDX_HDR_FIRST = IDX_BITS'(0);
   localparam logic [IDX_BITS-1:0] IDX_BLUE      = IDX_BITS'(HDR_LEN);
   localparam logic [IDX_BITS-1:0] IDX_GREEN     = IDX_BITS'(HDR_LEN + 1);
   localparam logic [IDX_BITS-1:0] IDX_RED       = IDX_BITS'(HDR_LEN + 2);

   // pixel being serialized
   typedef struct packed {
      logic [PIX_BITS-1:0] pixel_word;
      logic [IDX_BITS-1:0] last_idx;
      logic                end_of_frame;
   } item_type;

endpackage

[hdl/bmp24_stream_writer_core.sv]
// path: a request passes through the item register and then the result register to rsp
// output: 3 bytes per pixel, 57 for the first pixel of a frame, plus
//   (image_width & 3) pad bytes on the last pixel of each row; the single
//   byte-wide result register holds one byte at a time
// reset: synchronous, clears counters, header flag, valid flags, byte index and configuration registers
// ---------------------------------------------------------------------------
// bmp24 stream writer core
// turns 16-bit panel pixel words into the byte stream of a top-down 24-bit bmp
// ---------------------------------------------------------------------------
module bmp24_stream_writer_core (
   input  logic                                clock,
   input  logic                                reset,
   // request: tdata = pixel_word[15:0]
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [15:0]                         req_tdata,
   // result: tdata = byte_value[7:0]; tlast = last_of_run; tuser = end_of_frame
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [7:0]                          rsp_tdata,
   output logic                                rsp_tlast,
   output logic                                rsp_tuser,
   // configuration write port
   input  logic                                csr_we,
   input  logic                                csr_index,
   input  logic [bmp24sw_pkg::DIM_BITS-1:0]    csr_wdata
);

   localparam int DB = bmp24sw_pkg::DIM_BITS;
   localparam int IB = bmp24sw_pkg::IDX_BITS;
   localparam int HDR_BITS_W = bmp24sw_pkg::HDR_LEN * 8;

   logic [DB-1:0]                     width_ff, height_ff;
   logic [bmp24sw_pkg::IMG_BITS-1:0]  img_ff, img_in;
   logic [bmp24sw_pkg::ROW_BITS-1:0]  row_bytes;
   logic [DB-1:0]                     col_ff, col_in, row_ff, row_in;
   logic                              hdr_sent_ff, hdr_sent_in;
   logic                              item_valid_ff, item_valid_in;
   bmp24sw_pkg::item_type             item_ff, item_in;
   logic [IB-1:0]                     idx_ff, idx_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [7:0]                        rsp_data_ff, rsp_data_in;
   logic                              rsp_last_ff, rsp_last_in;
   logic                              rsp_eof_ff, rsp_eof_in;

   logic                              req_take, out_load, item_done;
   logic                              row_end, frame_end;
   logic [1:0]                        pad;
   logic [4:0]                        r5, b5;
   logic [5:0]                        g6;
   logic [31:0]                       file32, img32, width32, negh32;
   logic [HDR_BITS_W-1:0]             hdr_vec;
   logic [7:0]                        hdr_byte, pix_byte, cur_byte;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= bmp24sw_pkg::WIDTH_RESET;
         height_ff <= bmp24sw_pkg::HEIGHT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            bmp24sw_pkg::REG_WIDTH:  width_ff  <= csr_wdata;
            bmp24sw_pkg::REG_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // image size: padded row bytes times rows, registered after the multiply
   always_comb begin
      row_bytes = bmp24sw_pkg::ROW_BITS'(width_ff) * bmp24sw_pkg::ROW_BITS'(3)
                  + bmp24sw_pkg::ROW_BITS'(3);
      row_bytes[1:0] = 2'b00;
      img_in = bmp24sw_pkg::IMG_BITS'(row_bytes) * bmp24sw_pkg::IMG_BITS'(height_ff);
   end

   always_ff @(posedge clock) begin
      img_ff <= img_in;
   end

   // handshake control
   assign out_load   = item_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign item_done  = out_load && (idx_ff == item_ff.last_idx);
   assign req_tready = !item_valid_ff || item_done;
   assign req_take   = req_tvalid && req_tready;

   // row and frame position of the incoming pixel
   always_comb begin
      row_end   = ({1'b0, col_ff} + (DB+1)'(1)) >= {1'b0, width_ff};
      frame_end = row_end && (({1'b0, row_ff} + (DB+1)'(1)) >= {1'b0, height_ff});
      pad       = row_end ? width_ff[1:0] : 2'b00;

      col_in      = col_ff;
      row_in      = row_ff;
      hdr_sent_in = hdr_sent_ff;
      item_in     = item_ff;
      idx_in      = idx_ff;
      item_valid_in = item_valid_ff;

      if (out_load) begin
         idx_in = idx_ff + IB'(1);
      end
      if (item_done) begin
         item_valid_in = 1'b0;
      end

      if (req_take) begin
         item_valid_in        = 1'b1;
         item_in.pixel_word   = req_tdata;
         item_in.last_idx     = bmp24sw_pkg::IDX_RED + IB'(pad);
         item_in.end_of_frame = frame_end;
         idx_in = hdr_sent_ff ? bmp24sw_pkg::IDX_BLUE : bmp24sw_pkg::IDX_HDR_FIRST;
         hdr_sent_in = !frame_end;
         if (row_end) begin
            col_in = '0;
            row_in = frame_end ? '0 : row_ff + DB'(1);
         end else begin
            col_in = col_ff + DB'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff        <= '0;
         row_ff        <= '0;
         hdr_sent_ff   <= 1'b0;
         item_valid_ff <= 1'b0;
         idx_ff        <= '0;
      end else begin
         col_ff        <= col_in;
         row_ff        <= row_in;
         hdr_sent_ff   <= hdr_sent_in;
         item_valid_ff <= item_valid_in;
         idx_ff        <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   // header image, lowest byte first
   always_comb begin
      img32   = 32'(img_ff);
      file32  = img32 + 32'(bmp24sw_pkg::HDR_LEN);
      width32 = 32'(width_ff);
      negh32  = 32'(0) - 32'(height_ff);
      hdr_vec = {128'h0, img32, 32'h0, 16'(bmp24sw_pkg::BPP), 16'd1, negh32, width32,
                 32'(bmp24sw_pkg::INFO_LEN), 32'(bmp24sw_pkg::HDR_LEN), 32'h0, file32,
                 8'h4D, 8'h42};
      hdr_byte = hdr_vec[{idx_ff, 3'b000} +: 8];
   end

   // unswizzle panel lanes and widen to 8 bits per channel
   always_comb begin
      r5 = item_ff.pixel_word[7:3];
      g6 = {item_ff.pixel_word[2:0], item_ff.pixel_word[15:13]};
      b5 = item_ff.pixel_word[12:8];
      case (idx_ff)
         bmp24sw_pkg::IDX_BLUE:  pix_byte = {b5, b5[4:2]};
         bmp24sw_pkg::IDX_GREEN: pix_byte = {g6, g6[5:4]};
         bmp24sw_pkg::IDX_RED:   pix_byte = {r5, r5[4:2]};
         default:                pix_byte = 8'h00;
      endcase
      cur_byte = (idx_ff < bmp24sw_pkg::IDX_BLUE) ? hdr_byte : pix_byte;
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_eof_in   = rsp_eof_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = cur_byte;
         rsp_last_in  = item_done;
         rsp_eof_in   = item_done && item_ff.end_of_frame;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      rsp_eof_ff  <= rsp_eof_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_eof_ff;

endmodule

[hdl/bmp24sw_checker.sv]
// ---------------------------------------------------------------------------
// bmp24 stream writer port checker
// watches the top level ports for handshake and framing slips
// ---------------------------------------------------------------------------
`include "bmp24_stream_writer_core_macros.svh"

module bmp24sw_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [7:0]                       rsp_tdata,
   input logic                             rsp_tlast,
   input logic                             rsp_tuser
);

   logic rsp_stall;

   assign rsp_stall = rsp_tvalid && !rsp_tready;

   // end of file only on the closing byte of a request
   `BSW_ASSERT_IMPLIES(a_eof_is_last, clock, reset, rsp_tvalid && rsp_tuser, rsp_tlast)

   // no result survives reset
   `BSW_ASSERT_NEXT_ALWAYS(a_reset_clears, clock, reset, !rsp_tvalid)

   // a stalled result stays offered
   `BSW_ASSERT_NEXT(a_hold_valid, clock, reset, rsp_stall, rsp_tvalid)

   // a stalled result keeps its payload
   `BSW_ASSERT_NEXT(a_hold_data, clock, reset, rsp_stall,
      $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser))

endmodule

bind bmp24_stream_writer_core bmp24sw_checker u_bmp24sw_checker (.*);
